### sv/i2cst_pkg.sv
// ----------------------------------------------------------------------------
// i2cst_pkg
// Shared types, constants and the divider step for the SCL timing calculator.
// ----------------------------------------------------------------------------
package i2cst_pkg;

  localparam int unsigned DivW     = 18;
  localparam int unsigned SpeedW   = 12;
  localparam int unsigned WordW    = 16;

  localparam logic [DivW-1:0] IclkHs   = 18'd19200;
  localparam logic [DivW-1:0] IclkFast = 18'd9600;
  localparam logic [DivW-1:0] IclkStd  = 18'd4000;
  localparam logic [SpeedW-1:0] SpeedFastMax = 12'd400;
  localparam logic [SpeedW-1:0] SpeedStdMax  = 12'd100;
  localparam logic [WordW-1:0] LowAdj  = 16'd7;
  localparam logic [WordW-1:0] HighAdj = 16'd5;
  // fixed fast/standard times in high-speed mode: s = 19200 / 400 = 48
  localparam logic [WordW-1:0] HsFsLow  = 16'd25;
  localparam logic [WordW-1:0] HsFsHigh = 16'd11;
  // x / 3 == (x * Recip3) >> Recip3Sh for x < 2**19
  localparam logic [DivW:0] Recip3   = 19'd174763;
  localparam int unsigned   Recip3Sh = 19;
  // x / 75 for x < 2**11 and x / 125 for x < 2**13 by reciprocal multiply
  localparam logic [13:0]   Recip75    = 14'd1748;
  localparam int unsigned   Recip75Sh  = 17;
  localparam logic [13:0]   Recip125   = 14'd8389;
  localparam int unsigned   Recip125Sh = 20;

  localparam logic [1:0] MODE_STD  = 2'd0;
  localparam logic [1:0] MODE_FAST = 2'd1;
  localparam logic [1:0] MODE_HS   = 2'd2;

  localparam logic CFG_FCLK  = 1'b0;
  localparam logic CFG_FORCE = 1'b1;

  typedef struct packed {
    logic [1:0]       mode;
    logic             zero;
    logic [WordW-1:0] psc;
    logic [DivW-1:0]  dvd_b;
    logic [DivW-1:0]  dvs_b;
  } item_t;

  typedef struct packed {
    logic [DivW-1:0] rem;
    logic [DivW-1:0] quo;
    logic [DivW-1:0] dvs;
  } lane_t;

  typedef struct packed {
    logic [1:0]       mode;
    logic             zero;
    logic [WordW-1:0] psc;
    lane_t            b;
  } stage_t;

  function automatic lane_t div_step(lane_t l);
    logic [DivW:0] t;
    lane_t         r;
    t     = {l.rem, l.quo[DivW-1]};
    r.dvs = l.dvs;
    if (t >= {1'b0, l.dvs}) begin
      r.rem = DivW'(t - {1'b0, l.dvs});
      r.quo = {l.quo[DivW-2:0], 1'b1};
    end else begin
      r.rem = t[DivW-1:0];
      r.quo = {l.quo[DivW-2:0], 1'b0};
    end
    return r;
  endfunction

endpackage

### sv/i2cst_front.sv
// ----------------------------------------------------------------------------
// i2cst_front
// Classifies a speed request into mode, prescaler, dividend and divisor;
// two-entry queue.
// ----------------------------------------------------------------------------
module i2cst_front (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [i2cst_pkg::SpeedW-1:0]    in_speed_khz,
  input  logic [i2cst_pkg::DivW-1:0]      fclk_khz,
  input  logic                            force_fast,
  input  logic                            pop,
  output logic                            head_valid,
  output i2cst_pkg::item_t                head
);
  import i2cst_pkg::*;

  item_t      q_r [2];
  logic       wr_r, wr_nxt, rd_r, rd_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  item_t      cls;
  logic       hs, fast;
  logic [DivW-1:0] iclk;
  logic       push, do_pop;
  logic [12:0]      p_num;
  logic [26:0]      p_prod;
  logic [WordW-1:0] p_quo;

  always_comb begin
    hs   = in_speed_khz > SpeedFastMax;
    fast = !hs && (in_speed_khz > SpeedStdMax);
    if (hs || force_fast) iclk = IclkHs;
    else if (fast)        iclk = IclkFast;
    else                  iclk = IclkStd;
    // fclk / internal clock: drop the power-of-two factor, multiply by a reciprocal
    if (hs || force_fast) begin
      p_num  = {3'b000, fclk_khz[DivW-1:8]};
      p_prod = p_num * Recip75;
      p_quo  = WordW'(p_prod >> Recip75Sh);
    end else if (fast) begin
      p_num  = {2'b00, fclk_khz[DivW-1:7]};
      p_prod = p_num * Recip75;
      p_quo  = WordW'(p_prod >> Recip75Sh);
    end else begin
      p_num  = fclk_khz[DivW-1:5];
      p_prod = p_num * Recip125;
      p_quo  = WordW'(p_prod >> Recip125Sh);
    end
    cls.mode  = hs ? MODE_HS : (fast ? MODE_FAST : MODE_STD);
    cls.zero  = (in_speed_khz == '0);
    cls.psc   = p_quo - 16'd1;
    // standard mode divides by twice the speed: halve the dividend instead
    cls.dvd_b = hs ? fclk_khz : (fast ? iclk : {1'b0, iclk[DivW-1:1]});
    cls.dvs_b = DivW'(in_speed_khz);
  end

  assign in_stall   = (cnt_r == 2'd2);
  assign push       = in_valid && !in_stall;
  assign head_valid = (cnt_r != 2'd0);
  assign do_pop     = pop && head_valid;
  assign head       = q_r[rd_r];

  always_comb begin
    wr_nxt  = push   ? !wr_r : wr_r;
    rd_nxt  = do_pop ? !rd_r : rd_r;
    cnt_nxt = cnt_r + {1'b0, push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= 1'b0;
      rd_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) q_r[wr_r] <= cls;
  end

endmodule

### sv/i2cst_back.sv
// ----------------------------------------------------------------------------
// i2cst_back
// Pipelined restoring divider, one quotient bit per stage, then time split.
// ----------------------------------------------------------------------------
module i2cst_back (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          head_valid,
  input  i2cst_pkg::item_t              head,
  output logic                          pop,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [i2cst_pkg::WordW-1:0]   out_prescaler,
  output logic [i2cst_pkg::WordW-1:0]   out_scl_low_word,
  output logic [i2cst_pkg::WordW-1:0]   out_scl_high_word,
  output logic                          out_high_speed
);
  import i2cst_pkg::*;

  stage_t         st_r   [DivW];
  stage_t         st_nxt [DivW];
  logic [DivW-1:0] vld_r, vld_nxt;
  logic           en;
  stage_t         init;

  logic           ovld_r, ovld_nxt;
  logic [WordW-1:0] psc_r, lo_r, hi_r;
  logic           hs_r;
  logic [WordW-1:0] psc_nxt, lo_nxt, hi_nxt;

  stage_t         fin;
  logic [DivW-1:0] s;
  logic [2*DivW:0] prod;
  logic [WordW-1:0] s3, t_lo, t_hi, fs_lo, fs_hi, hs_lo, hs_hi, q;

  // advance the whole pipe unless the result register is held
  assign en  = !ovld_r || !out_stall;
  assign pop = en;

  always_comb begin
    init.mode  = head.mode;
    init.zero  = head.zero;
    init.psc   = head.psc;
    init.b.rem = '0;
    init.b.quo = head.dvd_b;
    init.b.dvs = head.dvs_b;
    for (int k = 0; k < DivW; k++) begin
      st_nxt[k] = (k == 0) ? init : st_r[(k == 0) ? 0 : k-1];
      st_nxt[k].b = div_step(st_nxt[k].b);
    end
    vld_nxt = {vld_r[DivW-2:0], head_valid};
  end

  always_comb begin
    fin   = st_r[DivW-1];
    s     = fin.b.quo;
    prod  = s * Recip3;
    s3    = WordW'(prod >> Recip3Sh);
    t_lo  = WordW'(s) - s3 - LowAdj;
    t_hi  = s3 - HighAdj;
    q     = fin.zero ? '0 : WordW'(s);
    hs_lo = '0;
    hs_hi = '0;
    case (fin.mode)
      MODE_HS: begin
        fs_lo = HsFsLow;
        fs_hi = HsFsHigh;
        hs_lo = t_lo;
        hs_hi = t_hi;
      end
      MODE_FAST: begin
        fs_lo = t_lo;
        fs_hi = t_hi;
      end
      default: begin
        fs_lo = q - LowAdj;
        fs_hi = q - HighAdj;
      end
    endcase
    psc_nxt  = fin.psc;
    lo_nxt   = {hs_lo[7:0], 8'h00} | fs_lo;
    hi_nxt   = {hs_hi[7:0], 8'h00} | fs_hi;
    ovld_nxt = vld_r[DivW-1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r  <= '0;
      ovld_r <= 1'b0;
    end else if (en) begin
      vld_r  <= vld_nxt;
      ovld_r <= ovld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < DivW; k++) st_r[k] <= st_nxt[k];
      psc_r <= psc_nxt;
      lo_r  <= lo_nxt;
      hi_r  <= hi_nxt;
      hs_r  <= (fin.mode == MODE_HS);
    end
  end

  assign out_valid         = ovld_r;
  assign out_prescaler     = psc_r;
  assign out_scl_low_word  = lo_r;
  assign out_scl_high_word = hi_r;
  assign out_high_speed    = hs_r;

endmodule

### sv/i2c_scl_timing_calc.sv
// Path: an accepted request passes the queue, then the 18 divider stages
// of one quotient bit each, then the result register.
// Throughput: one request per cycle unless a stalled result holds the pipe.
// Reset: rst_n low clears queue, pipe valids and result valid; fclk_r
// returns to 96000 and force_r to 0.
// ----------------------------------------------------------------------------
// i2c_scl_timing_calc
// Prescaler and SCL low/high timing words from a requested bus speed.
// ----------------------------------------------------------------------------
module i2c_scl_timing_calc (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [i2cst_pkg::SpeedW-1:0]  in_speed_khz,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [i2cst_pkg::WordW-1:0]   out_prescaler,
  output logic [i2cst_pkg::WordW-1:0]   out_scl_low_word,
  output logic [i2cst_pkg::WordW-1:0]   out_scl_high_word,
  output logic                          out_high_speed,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic                          cfg_index,
  input  logic [i2cst_pkg::DivW-1:0]    cfg_data
);
  import i2cst_pkg::*;

  logic [DivW-1:0] fclk_r;
  logic            force_r;
  logic            head_valid, pop;
  item_t           head;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fclk_r  <= 18'd96000;
      force_r <= 1'b0;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_FCLK:  fclk_r  <= cfg_data;
        CFG_FORCE: force_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  i2cst_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_speed_khz (in_speed_khz),
    .fclk_khz     (fclk_r),
    .force_fast   (force_r),
    .pop          (pop),
    .head_valid   (head_valid),
    .head         (head)
  );

  i2cst_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .head_valid        (head_valid),
    .head              (head),
    .pop               (pop),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_prescaler     (out_prescaler),
    .out_scl_low_word  (out_scl_low_word),
    .out_scl_high_word (out_scl_high_word),
    .out_high_speed    (out_high_speed)
  );

endmodule

### verif/i2c_scl_timing_calc_tb.sv
// ----------------------------------------------------------------------------
// i2c_scl_timing_calc_tb
// Drives speed requests through the SCL timing calculator under random valid
// and stall gaps, predicts prescaler and timing words, and compares in order.
// ----------------------------------------------------------------------------
module i2c_scl_timing_calc_tb;
  import i2cst_pkg::*;

  typedef struct packed {
    logic [WordW-1:0] prescaler;
    logic [WordW-1:0] low_word;
    logic [WordW-1:0] high_word;
    logic             high_speed;
  } timing_t;

  typedef struct {
    logic [SpeedW-1:0] speed;
    bit                known;
    timing_t           res;
  } row_t;

  localparam int unsigned CycleLimit = 400000;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  logic [SpeedW-1:0]  in_speed_khz;
  logic               out_valid;
  logic               out_stall;
  logic [WordW-1:0]   out_prescaler;
  logic [WordW-1:0]   out_scl_low_word;
  logic [WordW-1:0]   out_scl_high_word;
  logic               out_high_speed;
  logic               cfg_valid;
  logic               cfg_ready;
  logic               cfg_index;
  logic [DivW-1:0]    cfg_data;

  logic [17:0] fclk_khz;
  bit          force_fast;
  timing_t     timing_q[$];
  bit          failed = 1'b0;
  int unsigned cycles = 0;
  row_t        rows[$];
  int unsigned ostall_left;
  bit          ostall_drawn;
  bit          ovld_prev;

  i2c_scl_timing_calc u_dut (.*);

  initial begin
    clk = 1'b0;
  end
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic timing_t calc_timing(logic [SpeedW-1:0] spd, logic [17:0] fclk,
                                          bit frc);
    logic [31:0] iclk, s, t, q, fl, fh, hl, hh;
    timing_t     r;
    bit          hs;
    hs = spd > 400;
    fl = 0; fh = 0; hl = 0; hh = 0;
    if (hs || frc) iclk = 19200;
    else if (spd > 100) iclk = 9600;
    else iclk = 4000;
    r.prescaler = 16'(fclk / iclk - 1);
    if (hs) begin
      s  = iclk / 400;
      fl = (s - s / 3 - 7) & 32'hFFFF;
      fh = (s / 3 - 5) & 32'hFFFF;
      t  = fclk / spd;
      hl = (t - t / 3 - 7) & 32'hFFFF;
      hh = (t / 3 - 5) & 32'hFFFF;
    end else if (spd > 100) begin
      s  = iclk / spd;
      fl = (s - s / 3 - 7) & 32'hFFFF;
      fh = (s / 3 - 5) & 32'hFFFF;
    end else begin
      q  = (spd == 0) ? 0 : iclk / (spd * 2);
      fl = (q - 7) & 32'hFFFF;
      fh = (q - 5) & 32'hFFFF;
    end
    r.low_word   = 16'((hl << 8) | fl);
    r.high_word  = 16'((hh << 8) | fh);
    r.high_speed = hs;
    return r;
  endfunction

  task automatic write_reg(logic idx, logic [DivW-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    if (idx == CFG_FCLK) fclk_khz = val;
    else force_fast = val[0];
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // drop valid, hold until the pipe has drained, then leave margin for latency
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (timing_q.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  // valid stays high after a transaction so that a zero gap runs back to back
  task automatic send_speed(logic [SpeedW-1:0] spd, bit known, timing_t res);
    int unsigned gap;
    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 16);
    @(negedge clk);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid     <= 1'b1;
    in_speed_khz <= spd;
    do @(posedge clk); while (in_stall);
    if (known) timing_q.push_back(res);
    else timing_q.push_back(calc_timing(spd, fclk_khz, force_fast));
  endtask

  task automatic random_phase(int unsigned n);
    logic [SpeedW-1:0] spd;
    timing_t           none;
    none = '0;
    repeat (n) begin
      case ($urandom_range(0, 5))
        0: spd = SpeedW'($urandom_range(0, 100));
        1: spd = SpeedW'($urandom_range(101, 400));
        2: spd = SpeedW'($urandom_range(401, 3400));
        3: spd = SpeedW'($urandom_range(3401, 4095));
        default: spd = SpeedW'($urandom);
      endcase
      send_speed(spd, 1'b0, none);
    end
  endtask

  // draw a wait for every result, stall for that many cycles, then take it
  always @(negedge clk) begin
    if (!rst_n) begin
      out_stall    <= 1'b0;
      ostall_left  = 0;
      ostall_drawn = 1'b0;
      ovld_prev    = 1'b0;
    end else begin
      if (ovld_prev && !out_stall) ostall_drawn = 1'b0;
      if (out_valid && !ostall_drawn) begin
        ostall_left  = $urandom_range(0, 16);
        ostall_drawn = 1'b1;
      end
      if (ostall_left != 0) begin
        out_stall   <= 1'b1;
        ostall_left = ostall_left - 1;
      end else begin
        out_stall <= 1'b0;
      end
      ovld_prev = out_valid;
    end
  end

  always @(posedge clk) begin
    timing_t got, want;
    if (rst_n && out_valid && !out_stall) begin
      got = '{out_prescaler, out_scl_low_word, out_scl_high_word, out_high_speed};
      if (timing_q.size() == 0) begin
        $display("%0t: result with none pending: %h", $time, got);
        failed = 1'b1;
      end else begin
        want = timing_q.pop_front();
        if (got.prescaler != want.prescaler) begin
          $display("%0t: prescaler exp %h got %h", $time, want.prescaler, got.prescaler);
          failed = 1'b1;
        end
        if (got.low_word != want.low_word) begin
          $display("%0t: scl_low_word exp %h got %h", $time, want.low_word, got.low_word);
          failed = 1'b1;
        end
        if (got.high_word != want.high_word) begin
          $display("%0t: scl_high_word exp %h got %h", $time, want.high_word,
                   got.high_word);
          failed = 1'b1;
        end
        if (got.high_speed != want.high_speed) begin
          $display("%0t: high_speed exp %b got %b", $time, want.high_speed,
                   got.high_speed);
          failed = 1'b1;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("[i2c_scl_timing_calc] ERROR");
      $finish;
    end
  end

  initial begin
    timing_t none;
    none         = '0;
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_speed_khz = '0;
    cfg_valid    = 1'b0;
    cfg_index    = CFG_FCLK;
    cfg_data     = '0;
    fclk_khz     = 18'd96000;
    force_fast   = 1'b0;
    // directed rows after reset (fclk 96000, no force)
    rows.push_back('{12'd0, 1'b1, '{16'd23, 16'hFFF9, 16'hFFFB, 1'b0}});
    rows.push_back('{12'd1, 1'b1, '{16'd23, 16'd1993, 16'd1995, 1'b0}});
    rows.push_back('{12'd100, 1'b1, '{16'd23, 16'd13, 16'd15, 1'b0}});
    rows.push_back('{12'd101, 1'b1, '{16'd9, 16'd57, 16'd26, 1'b0}});
    rows.push_back('{12'd400, 1'b1, '{16'd9, 16'd9, 16'd3, 1'b0}});
    rows.push_back('{12'd401, 1'b0, none});
    rows.push_back('{12'd3400, 1'b0, none});
    rows.push_back('{12'd3401, 1'b0, none});
    rows.push_back('{12'd4095, 1'b0, none});
    rows.push_back('{12'd2730, 1'b0, none});
    rows.push_back('{12'd1365, 1'b0, none});
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    foreach (rows[i]) send_speed(rows[i].speed, rows[i].known, rows[i].res);
    drain();
    write_reg(CFG_FORCE, 18'd1);
    foreach (rows[i]) send_speed(rows[i].speed, 1'b0, none);
    random_phase(200);
    drain();
    write_reg(CFG_FCLK, 18'd0);
    foreach (rows[i]) send_speed(rows[i].speed, 1'b0, none);
    drain();
    write_reg(CFG_FORCE, 18'd0);
    write_reg(CFG_FCLK, 18'h3FFFF);
    random_phase(200);
    drain();
    write_reg(CFG_FCLK, 18'd1);
    random_phase(150);
    drain();
    repeat (6) begin
      write_reg(CFG_FCLK, 18'($urandom_range(1, 262143)));
      write_reg(CFG_FORCE, 18'($urandom_range(0, 1)));
      random_phase(200);
      drain();
    end
    if (!failed && timing_q.size() == 0) begin
      $display("[i2c_scl_timing_calc] OK");
    end else begin
      $display("[i2c_scl_timing_calc] ERROR");
    end
    $finish;
  end

endmodule

### files.f
sv/i2cst_pkg.sv
sv/i2cst_front.sv
sv/i2cst_back.sv
sv/i2c_scl_timing_calc.sv
verif/i2c_scl_timing_calc_tb.sv
